// ===== src/ptr_pkg.sv =====
// Package for the PCIe configuration and memory requester.
// Holds codes, register layout, result item type and header helpers.
// No dependencies; used by every module of the block.
`default_nettype none

package ptr_pkg;

   localparam int CSR_AW = 4;

   localparam logic [1:0] REG_RID     = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_BACKOFF = 2'd2;
   localparam logic [1:0] REG_RETRY   = 2'd3;

   localparam logic [15:0] RID_RESET     = 16'h10EE;
   localparam logic [23:0] TIMEOUT_RESET = 24'd2000000;
   localparam logic [15:0] BACKOFF_RESET = 16'd1000;
   localparam logic [7:0]  RETRY_RESET   = 8'd100;

   localparam logic [1:0] REQ_HOST = 2'd0;
   localparam logic [1:0] REQ_CPL  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam logic [1:0] OP_CFG_RD = 2'd0;
   localparam logic [1:0] OP_CFG_WR = 2'd1;
   localparam logic [1:0] OP_MEM_RD = 2'd2;
   localparam logic [1:0] OP_MEM_WR = 2'd3;

   localparam logic [2:0] CPL_SC  = 3'd0;
   localparam logic [2:0] CPL_CRS = 3'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CPL_ERR   = 3'd1;
   localparam logic [2:0] ST_TIMEOUT   = 3'd2;
   localparam logic [2:0] ST_EXHAUSTED = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;

   localparam logic [0:0] KIND_TLP  = 1'b0;
   localparam logic [0:0] KIND_DONE = 1'b1;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] FMT_CFG_RD = 32'h0400_0000;
   localparam logic [31:0] FMT_CFG_WR = 32'h4400_0000;
   localparam logic [31:0] FMT_MEM_RD = 32'h0000_0000;
   localparam logic [31:0] FMT_MEM_WR = 32'h4000_0000;
   localparam logic [31:0] LEN_ONE    = 32'h0000_0001;
   localparam logic [7:0]  BYTE_EN    = 8'h0F;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_BACKOFF
   } phase_type;

   typedef struct packed {
      logic [15:0] requester_id;
      logic [23:0] timeout_ticks;
      logic [15:0] backoff_ticks;
      logic [7:0]  retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [0:0]  kind;
      logic        posted;
      logic [31:0] header0;
      logic [31:0] header1;
      logic [31:0] header2;
      logic [31:0] payload;
      logic [31:0] done_data;
      logic [2:0]  done_status;
   } res_type;

   function automatic logic [31:0] header0_of(input logic [1:0] op);
      logic [31:0] fmt;
      case (op)
         OP_CFG_RD: fmt = FMT_CFG_RD;
         OP_CFG_WR: fmt = FMT_CFG_WR;
         OP_MEM_RD: fmt = FMT_MEM_RD;
         default:   fmt = FMT_MEM_WR;
      endcase
      return fmt | LEN_ONE;
   endfunction

   function automatic res_type make_tlp(input logic [1:0] op, input logic [15:0] rid,
                                        input logic [7:0] tag, input logic [31:0] h2,
                                        input logic [31:0] payload, input logic posted);
      res_type r;
      r.kind        = KIND_TLP;
      r.posted      = posted;
      r.header0     = header0_of(op);
      r.header1     = {rid, tag, BYTE_EN};
      r.header2     = h2;
      r.payload     = payload;
      r.done_data   = '0;
      r.done_status = ST_OK;
      return r;
   endfunction

   function automatic res_type make_done(input logic [31:0] data, input logic [2:0] status);
      res_type r;
      r.kind        = KIND_DONE;
      r.posted      = 1'b0;
      r.header0     = '0;
      r.header1     = '0;
      r.header2     = '0;
      r.payload     = '0;
      r.done_data   = data;
      r.done_status = status;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/ptr_csr.sv =====
// Configuration registers of the requester behind an APB-style port.
// Depends on ptr_pkg for the register map and reset values.
`default_nettype none

module ptr_csr
   import ptr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output      logic [31:0]       csr_prdata,
   output      logic              csr_pready,
   output      cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RID:     cfg_in.requester_id  = csr_pwdata[15:0];
            REG_TIMEOUT: cfg_in.timeout_ticks = csr_pwdata[23:0];
            REG_BACKOFF: cfg_in.backoff_ticks = csr_pwdata[15:0];
            REG_RETRY:   cfg_in.retry_limit   = csr_pwdata[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RID:     csr_prdata = {16'd0, cfg_ff.requester_id};
         REG_TIMEOUT: csr_prdata = {8'd0, cfg_ff.timeout_ticks};
         REG_BACKOFF: csr_prdata = {16'd0, cfg_ff.backoff_ticks};
         REG_RETRY:   csr_prdata = {24'd0, cfg_ff.retry_limit};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.requester_id  <= RID_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.backoff_ticks <= BACKOFF_RESET;
         cfg_ff.retry_limit   <= RETRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ptr_engine.sv =====
// Request engine: phase machine, tag, timers and retry count; builds at most one result
// item per accepted item. Depends on ptr_pkg.
`default_nettype none

module ptr_engine
   import ptr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        accept,
   input  wire logic [1:0]  req_type,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_bus_num,
   input  wire logic [4:0]  req_dev_num,
   input  wire logic [2:0]  req_func_num,
   input  wire logic [7:0]  req_reg_offset,
   input  wire logic [31:0] req_mem_addr,
   input  wire logic [31:0] req_data_word,
   input  wire logic [15:0] req_cpl_requester,
   input  wire logic [7:0]  req_cpl_tag,
   input  wire logic [2:0]  req_cpl_status,
   output      logic        push,
   output      res_type     entry
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  active_tag_ff, active_tag_in;
   logic [1:0]  active_op_ff, active_op_in;
   logic [31:0] target_ff, target_in;
   logic [23:0] wait_ff, wait_in;
   logic [7:0]  attempt_ff, attempt_in;

   logic        active_read;
   logic        cpl_match;
   logic        wait_le1;
   logic        exhausted;
   logic        no_backoff;
   logic [31:0] new_h2;
   logic [31:0] new_payload;

   assign active_read = (active_op_ff == OP_CFG_RD) || (active_op_ff == OP_MEM_RD);
   assign cpl_match   = (phase_ff == PH_WAIT) && (req_cpl_requester == cfg.requester_id)
                        && (req_cpl_tag == active_tag_ff);
   assign wait_le1    = (wait_ff <= 24'd1);
   assign exhausted   = (attempt_ff >= cfg.retry_limit);
   assign no_backoff  = (cfg.backoff_ticks == 16'd0);
   assign new_h2      = (req_op == OP_CFG_RD || req_op == OP_CFG_WR)
                        ? {req_bus_num, req_dev_num, req_func_num, 8'd0,
                           req_reg_offset[7:2], 2'b00}
                        : {req_mem_addr[31:2], 2'b00};
   assign new_payload = (req_op == OP_CFG_WR || req_op == OP_MEM_WR) ? req_data_word : '0;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (req_type)
            REQ_HOST: begin
               if (phase_ff == PH_IDLE && req_op != OP_MEM_WR) phase_in = PH_WAIT;
            end
            REQ_CPL: begin
               if (cpl_match) begin
                  if (req_cpl_status == CPL_CRS && active_read && !exhausted) begin
                     phase_in = no_backoff ? PH_WAIT : PH_BACKOFF;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            REQ_TICK: begin
               case (phase_ff)
                  PH_WAIT:    if (wait_le1) phase_in = PH_IDLE;
                  PH_BACKOFF: if (wait_le1) phase_in = PH_WAIT;
                  default:    phase_in = phase_ff;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_comb begin
      push          = 1'b0;
      entry         = make_done(ALL_ONES, ST_BUSY);
      tag_in        = tag_ff;
      active_tag_in = active_tag_ff;
      active_op_in  = active_op_ff;
      target_in     = target_ff;
      wait_in       = wait_ff;
      attempt_in    = attempt_ff;
      if (accept) begin
         case (req_type)
            REQ_HOST: begin
               push = 1'b1;
               if (phase_ff == PH_IDLE) begin
                  tag_in = tag_ff + 8'd1;
                  entry  = make_tlp(req_op, cfg.requester_id, tag_ff, new_h2, new_payload,
                                    req_op == OP_MEM_WR);
                  if (req_op != OP_MEM_WR) begin
                     active_tag_in = tag_ff;
                     active_op_in  = req_op;
                     target_in     = new_h2;
                     wait_in       = cfg.timeout_ticks;
                     attempt_in    = '0;
                  end
               end
            end
            REQ_CPL: begin
               if (cpl_match) begin
                  push = 1'b1;
                  if (req_cpl_status == CPL_SC) begin
                     entry = make_done(active_read ? req_data_word : '0, ST_OK);
                  end else if (req_cpl_status == CPL_CRS && active_read) begin
                     if (exhausted) begin
                        entry = make_done(ALL_ONES, ST_EXHAUSTED);
                     end else begin
                        attempt_in = attempt_ff + 8'd1;
                        if (no_backoff) begin
                           tag_in        = tag_ff + 8'd1;
                           active_tag_in = tag_ff;
                           wait_in       = cfg.timeout_ticks;
                           entry         = make_tlp(active_op_ff, cfg.requester_id, tag_ff,
                                                    target_ff, '0, 1'b0);
                        end else begin
                           push    = 1'b0;
                           wait_in = {8'd0, cfg.backoff_ticks};
                        end
                     end
                  end else begin
                     entry = make_done(ALL_ONES, ST_CPL_ERR);
                  end
               end
            end
            REQ_TICK: begin
               case (phase_ff)
                  PH_WAIT: begin
                     if (wait_le1) begin
                        push    = 1'b1;
                        wait_in = '0;
                        entry   = make_done(ALL_ONES, ST_TIMEOUT);
                     end else begin
                        wait_in = wait_ff - 24'd1;
                     end
                  end
                  PH_BACKOFF: begin
                     if (wait_le1) begin
                        push          = 1'b1;
                        tag_in        = tag_ff + 8'd1;
                        active_tag_in = tag_ff;
                        wait_in       = cfg.timeout_ticks;
                        entry         = make_tlp(active_op_ff, cfg.requester_id, tag_ff,
                                                 target_ff, '0, 1'b0);
                     end else begin
                        wait_in = wait_ff - 24'd1;
                     end
                  end
                  default: wait_in = wait_ff;
               endcase
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tag_ff        <= '0;
         active_tag_ff <= '0;
         active_op_ff  <= '0;
         target_ff     <= '0;
         wait_ff       <= '0;
         attempt_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         tag_ff        <= tag_in;
         active_tag_ff <= active_tag_in;
         active_op_ff  <= active_op_in;
         target_ff     <= target_in;
         wait_ff       <= wait_in;
         attempt_ff    <= attempt_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/pcie_tlp_requester.sv =====
// PCIe configuration and memory requester: one outstanding request, tag assignment,
// completion matching, timeout and read retry with backoff. The engine takes one item per
// clock while req_stall is low (host request, received completion or time tick) and its
// result item is registered; a skid stage behind the output register lets the next item
// in while a result waits, and req_stall rises only when that skid stage is full. Each
// result item is one beat on the result channel; a memory write gives two (its TLP, then
// the posted finish), so it holds the output register until both are taken. Time ticks
// arrive as input items, so timeout and backoff counts are in ticks, not clocks.
// Depends on ptr_pkg, ptr_csr and ptr_engine.
`default_nettype none

module pcie_tlp_requester
   import ptr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output      logic [31:0]       csr_prdata,
   output      logic              csr_pready,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [1:0]        req_type,
   input  wire logic [1:0]        req_op,
   input  wire logic [7:0]        req_bus_num,
   input  wire logic [4:0]        req_dev_num,
   input  wire logic [2:0]        req_func_num,
   input  wire logic [7:0]        req_reg_offset,
   input  wire logic [31:0]       req_mem_addr,
   input  wire logic [31:0]       req_data_word,
   input  wire logic [15:0]       req_cpl_requester,
   input  wire logic [7:0]        req_cpl_tag,
   input  wire logic [2:0]        req_cpl_status,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic              rsp_out_kind,
   output      logic              rsp_out_last,
   output      logic [31:0]       rsp_tlp_header0,
   output      logic [31:0]       rsp_tlp_header1,
   output      logic [31:0]       rsp_tlp_header2,
   output      logic [31:0]       rsp_tlp_payload,
   output      logic [31:0]       rsp_done_data,
   output      logic [2:0]        rsp_done_status
);

   cfg_type cfg;
   logic    accept;
   logic    push;
   res_type push_entry;

   logic    out_valid_ff, out_valid_in;
   logic    out_half_ff, out_half_in;
   res_type out_entry_ff, out_entry_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type skid_entry_ff, skid_entry_in;

   logic    out_pop;
   logic    out_free;
   logic    first_half_posted;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~req_stall;

   ptr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ptr_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .accept            (accept),
      .req_type          (req_type),
      .req_op            (req_op),
      .req_bus_num       (req_bus_num),
      .req_dev_num       (req_dev_num),
      .req_func_num      (req_func_num),
      .req_reg_offset    (req_reg_offset),
      .req_mem_addr      (req_mem_addr),
      .req_data_word     (req_data_word),
      .req_cpl_requester (req_cpl_requester),
      .req_cpl_tag       (req_cpl_tag),
      .req_cpl_status    (req_cpl_status),
      .push              (push),
      .entry             (push_entry)
   );

   assign first_half_posted = out_entry_ff.posted & ~out_half_ff;
   assign out_pop           = out_valid_ff & ~rsp_stall & ~first_half_posted;
   assign out_free          = ~out_valid_ff | out_pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_half_in   = out_half_ff;
      out_entry_in  = out_entry_ff;
      skid_valid_in = skid_valid_ff;
      skid_entry_in = skid_entry_ff;
      if (out_free) begin
         out_half_in = 1'b0;
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_entry_in  = skid_entry_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_entry_in = push_entry;
         end else begin
            out_valid_in = 1'b0;
         end
      end else begin
         if (out_valid_ff && !rsp_stall && first_half_posted) out_half_in = 1'b1;
         if (push) begin
            skid_valid_in = 1'b1;
            skid_entry_in = push_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         out_half_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         out_half_ff   <= out_half_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_entry_ff  <= out_entry_in;
      skid_entry_ff <= skid_entry_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_kind    = out_half_ff ? KIND_DONE : out_entry_ff.kind;
   assign rsp_out_last    = out_half_ff | ~out_entry_ff.posted;
   assign rsp_tlp_header0 = out_half_ff ? '0 : out_entry_ff.header0;
   assign rsp_tlp_header1 = out_half_ff ? '0 : out_entry_ff.header1;
   assign rsp_tlp_header2 = out_half_ff ? '0 : out_entry_ff.header2;
   assign rsp_tlp_payload = out_half_ff ? '0 : out_entry_ff.payload;
   assign rsp_done_data   = out_half_ff ? '0 : out_entry_ff.done_data;
   assign rsp_done_status = out_half_ff ? ST_OK : out_entry_ff.done_status;

endmodule

`default_nettype wire
